// ===== rtl/core/amg_direct_interpolation_row_core_macros.svh =====
// assertion macros for the interpolation row core
// no dependencies; included by the row core module, which checks itself
`ifndef AMG_DIRECT_INTERPOLATION_ROW_CORE_MACROS_SVH
`define AMG_DIRECT_INTERPOLATION_ROW_CORE_MACROS_SVH

// same-cycle implication
`define AMG_DIR_ASSERT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AMG_DIR_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/amg_dir_pkg.sv =====
// types, codes and double constants for the interpolation row core
// no dependencies
package amg_dir_pkg;

	localparam logic [63:0] DBL_ZERO    = 64'h0000_0000_0000_0000;
	localparam logic [63:0] DBL_ONE     = 64'h3FF0_0000_0000_0000;
	localparam logic [63:0] DBL_NEG_ONE = 64'hBFF0_0000_0000_0000;
	localparam logic [63:0] DBL_DNAN    = 64'hFFF8_0000_0000_0000;

	typedef struct packed {
		logic        row_is_coarse;
		logic [23:0] row_coarse_column;
		logic        is_diagonal;
		logic        strong_coarse;
		logic [23:0] neighbour_coarse_column;
		logic [63:0] entry_value;
		logic        last_entry;
	} in_item_t;

	typedef struct packed {
		logic [23:0] weight_column;
		logic [63:0] weight_value;
		logic        row_overflow;
		logic        last_weight;
	} out_item_t;

	typedef enum logic [1:0] {
		OP_ADD,
		OP_MUL,
		OP_DIV
	} fpu_op_t;

	typedef struct packed {
		logic        go;
		fpu_op_t     op;
		logic [63:0] a;
		logic [63:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] y;
	} fpu_rsp_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_ALIGN,
		F_MUL,
		F_PRENORM,
		F_DIV,
		F_NORM,
		F_ROUND,
		F_DONE
	} fpu_state_t;

	typedef enum logic [3:0] {
		C_IDLE,
		C_ACC_ALL,
		C_ACC_STRONG,
		C_END,
		C_ALPHA,
		C_BETA,
		C_RECIP,
		C_SCALE_A,
		C_SCALE_B,
		C_READ,
		C_WEIGHT
	} ctl_state_t;

	function automatic logic dbl_is_nan(input logic [63:0] v);
		return (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
	endfunction

	// strictly below zero: -0 and nan excluded
	function automatic logic dbl_is_neg(input logic [63:0] v);
		return v[63] && (v[62:0] != 63'd0) && !dbl_is_nan(v);
	endfunction

	function automatic logic dbl_is_pos(input logic [63:0] v);
		return !v[63] && (v[62:0] != 63'd0) && !dbl_is_nan(v);
	endfunction

endpackage

// ===== rtl/core/amg_dir_ram.sv =====
// generic single-port-write, registered-read ram
// no dependencies
module amg_dir_ram #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/amg_dir_fpu.sv =====
// shared multi-cycle ieee double unit: add, multiply, divide, round to nearest even
// depends on amg_dir_pkg
module amg_dir_fpu (
	input  logic                 clk,
	input  logic                 arst_n,
	input  amg_dir_pkg::fpu_req_t req,
	output amg_dir_pkg::fpu_rsp_t rsp
);
	import amg_dir_pkg::*;

	fpu_state_t st_q, st_d;

	// mantissa datapath: leading bit sits at 104, bit 105 catches a carry
	logic [105:0]       rm_q, sm_q;
	logic [52:0]        ma_q, mb_q;
	logic [53:0]        rem_q;
	logic [53:0]        pp_q;
	logic [6:0]         sh_q;
	logic signed [13:0] re_q, eb_q;
	logic [11:0]        d_q;
	logic [5:0]         cnt_q;
	logic               rs_q, sb_q, sub_q;
	logic [63:0]        y_q;

	// operand unpack
	logic               sa, sb;
	logic [10:0]        xa, xb;
	logic               nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic signed [13:0] ea_u, eb_u;
	logic [52:0]        ma_u, mb_u;
	logic               a_ge;
	logic signed [13:0] e_diff;

	assign sa     = req.a[63];
	assign sb     = req.b[63];
	assign xa     = req.a[62:52];
	assign xb     = req.b[62:52];
	assign nan_a  = dbl_is_nan(req.a);
	assign nan_b  = dbl_is_nan(req.b);
	assign inf_a  = (xa == 11'h7FF) && (req.a[51:0] == 52'd0);
	assign inf_b  = (xb == 11'h7FF) && (req.b[51:0] == 52'd0);
	assign zero_a = (req.a[62:0] == 63'd0);
	assign zero_b = (req.b[62:0] == 63'd0);
	assign ea_u   = (xa == 11'd0) ? 14'sd1 : $signed({3'b000, xa});
	assign eb_u   = (xb == 11'd0) ? 14'sd1 : $signed({3'b000, xb});
	assign ma_u   = {xa != 11'd0, req.a[51:0]};
	assign mb_u   = {xb != 11'd0, req.b[51:0]};
	assign a_ge   = ea_u >= eb_u;
	assign e_diff = a_ge ? (ea_u - eb_u) : (eb_u - ea_u);

	// special operands resolve without the datapath
	logic        spec;
	logic [63:0] spec_y;
	logic        sx;

	assign sx = sa ^ sb;

	always_comb begin
		spec   = 1'b1;
		spec_y = DBL_DNAN;
		if (nan_a) begin
			spec_y = req.a | 64'h0008_0000_0000_0000;
		end else if (nan_b) begin
			spec_y = req.b | 64'h0008_0000_0000_0000;
		end else begin
			unique case (req.op)
				OP_ADD: begin
					priority if (inf_a && inf_b && sx) spec_y = DBL_DNAN;
					else if (inf_a)                    spec_y = req.a;
					else if (inf_b)                    spec_y = req.b;
					else if (zero_a && zero_b)         spec_y = {sa & sb, 63'd0};
					else if (zero_a)                   spec_y = req.b;
					else if (zero_b)                   spec_y = req.a;
					else                               spec   = 1'b0;
				end
				OP_MUL: begin
					priority if ((inf_a && zero_b) || (zero_a && inf_b)) spec_y = DBL_DNAN;
					else if (inf_a || inf_b)   spec_y = {sx, 11'h7FF, 52'd0};
					else if (zero_a || zero_b) spec_y = {sx, 63'd0};
					else                       spec   = 1'b0;
				end
				OP_DIV: begin
					priority if ((inf_a && inf_b) || (zero_a && zero_b)) spec_y = DBL_DNAN;
					else if (inf_a)  spec_y = {sx, 11'h7FF, 52'd0};
					else if (inf_b)  spec_y = {sx, 63'd0};
					else if (zero_a) spec_y = {sx, 63'd0};
					else if (zero_b) spec_y = {sx, 11'h7FF, 52'd0};
					else             spec   = 1'b0;
				end
				default: spec_y = DBL_DNAN;
			endcase
		end
	end

	// aligned add / subtract
	logic         mag_ge;
	logic [105:0] add_res;
	logic         add_sign;

	assign mag_ge   = rm_q >= sm_q;
	assign add_res  = !sub_q ? (rm_q + sm_q) : (mag_ge ? (rm_q - sm_q) : (sm_q - rm_q));
	assign add_sign = (sub_q && !mag_ge) ? sb_q : rs_q;

	// one 27x27 partial product per cycle
	logic [26:0] a_part, b_part;
	logic [53:0] pp_c;
	logic [6:0]  sh_c;

	assign a_part = cnt_q[1] ? {1'b0, ma_q[52:27]} : ma_q[26:0];
	assign b_part = cnt_q[0] ? {1'b0, mb_q[52:27]} : mb_q[26:0];
	assign pp_c   = a_part * b_part;

	always_comb begin
		unique case (cnt_q[1:0])
			2'd0:    sh_c = 7'd0;
			2'd3:    sh_c = 7'd54;
			default: sh_c = 7'd27;
		endcase
	end

	// restoring divide, one quotient bit per cycle
	logic        q_ge;
	logic [53:0] q_diff;
	logic [56:0] q_all;

	assign q_ge   = rem_q >= {1'b0, mb_q};
	assign q_diff = q_ge ? (rem_q - {1'b0, mb_q}) : rem_q;
	assign q_all  = {rm_q[55:0], q_ge};

	// normalize and round
	logic               norm_ok;
	logic [52:0]        keep;
	logic               g_bit, s_bit, up;
	logic [53:0]        m54;
	logic [52:0]        mf;
	logic signed [13:0] ef;
	logic [63:0]        round_y;

	assign norm_ok = !rm_q[105] && (re_q >= 14'sd1) && (rm_q[104] || (re_q == 14'sd1));
	assign keep    = rm_q[104:52];
	assign g_bit   = rm_q[51];
	assign s_bit   = |rm_q[50:0];
	assign up      = g_bit && (s_bit || keep[0]);
	assign m54     = {1'b0, keep} + 54'(up);
	assign mf      = m54[53] ? m54[53:1] : m54[52:0];
	assign ef      = m54[53] ? (re_q + 14'sd1) : re_q;
	assign round_y = (ef >= 14'sd2047) ? {rs_q, 11'h7FF, 52'd0}
	                 : {rs_q, (mf[52] ? ef[10:0] : 11'd0), mf[51:0]};

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			F_IDLE: begin
				if (req.go) begin
					if (spec) begin
						st_d = F_DONE;
					end else begin
						unique case (req.op)
							OP_ADD:  st_d = F_ALIGN;
							OP_MUL:  st_d = F_MUL;
							OP_DIV:  st_d = F_PRENORM;
							default: st_d = F_DONE;
						endcase
					end
				end
			end
			F_ALIGN: begin
				if (d_q == 12'd0) begin
					st_d = (add_res == 106'd0) ? F_DONE : F_NORM;
				end
			end
			F_MUL:     if (cnt_q == 6'd4) st_d = F_NORM;
			F_PRENORM: if (ma_q[52] && mb_q[52]) st_d = F_DIV;
			F_DIV:     if (cnt_q == 6'd56) st_d = F_NORM;
			F_NORM:    if (norm_ok) st_d = F_ROUND;
			F_ROUND:   st_d = F_DONE;
			F_DONE:    st_d = F_IDLE;
			default:   st_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	// outputs
	always_comb begin
		rsp.done = (st_q == F_DONE);
		rsp.y    = y_q;
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			F_IDLE: begin
				if (req.go) begin
					y_q   <= spec_y;
					sub_q <= sx;
					cnt_q <= 6'd0;
					unique case (req.op)
						OP_ADD: begin
							if (a_ge) begin
								rm_q <= {1'b0, ma_u, 52'd0};
								sm_q <= {1'b0, mb_u, 52'd0};
								rs_q <= sa;
								sb_q <= sb;
								re_q <= ea_u;
							end else begin
								rm_q <= {1'b0, mb_u, 52'd0};
								sm_q <= {1'b0, ma_u, 52'd0};
								rs_q <= sb;
								sb_q <= sa;
								re_q <= eb_u;
							end
							d_q <= 12'(e_diff);
						end
						OP_MUL: begin
							ma_q <= ma_u;
							mb_q <= mb_u;
							rm_q <= '0;
							rs_q <= sx;
							re_q <= ea_u + eb_u - 14'sd1023;
						end
						default: begin
							ma_q <= ma_u;
							mb_q <= mb_u;
							rm_q <= '0;
							rs_q <= sx;
							re_q <= ea_u;
							eb_q <= eb_u;
						end
					endcase
				end
			end
			F_ALIGN: begin
				// shifted-out bits jam into bit 0
				if (d_q >= 12'd106) begin
					sm_q <= {105'd0, |sm_q};
					d_q  <= 12'd0;
				end else if (d_q >= 12'd8) begin
					sm_q <= {8'd0, sm_q[105:9], |sm_q[8:0]};
					d_q  <= d_q - 12'd8;
				end else if (d_q != 12'd0) begin
					sm_q <= {1'b0, sm_q[105:2], |sm_q[1:0]};
					d_q  <= d_q - 12'd1;
				end else begin
					rm_q <= add_res;
					rs_q <= add_sign;
					y_q  <= DBL_ZERO;
				end
			end
			F_MUL: begin
				if (cnt_q != 6'd0) begin
					rm_q <= rm_q + (106'(pp_q) << sh_q);
				end
				pp_q  <= pp_c;
				sh_q  <= sh_c;
				cnt_q <= cnt_q + 6'd1;
			end
			F_PRENORM: begin
				if (!ma_q[52]) begin
					if (ma_q[52:45] == 8'd0) begin
						ma_q <= {ma_q[44:0], 8'd0};
						re_q <= re_q - 14'sd8;
					end else begin
						ma_q <= {ma_q[51:0], 1'b0};
						re_q <= re_q - 14'sd1;
					end
				end
				if (!mb_q[52]) begin
					if (mb_q[52:45] == 8'd0) begin
						mb_q <= {mb_q[44:0], 8'd0};
						eb_q <= eb_q - 14'sd8;
					end else begin
						mb_q <= {mb_q[51:0], 1'b0};
						eb_q <= eb_q - 14'sd1;
					end
				end
				if (ma_q[52] && mb_q[52]) begin
					re_q  <= re_q - eb_q + 14'sd1023;
					rem_q <= {1'b0, ma_q};
				end
			end
			F_DIV: begin
				rem_q <= {q_diff[52:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd56) begin
					rm_q <= {1'b0, q_all, 48'd0} | 106'(q_diff != 54'd0);
				end else begin
					rm_q <= {rm_q[104:0], q_ge};
				end
			end
			F_NORM: begin
				if (rm_q[105]) begin
					rm_q <= {1'b0, rm_q[105:2], |rm_q[1:0]};
					re_q <= re_q + 14'sd1;
				end else if (re_q < 14'sd1) begin
					if (re_q < -14'sd107) begin
						rm_q <= {105'd0, |rm_q};
						re_q <= 14'sd1;
					end else if (re_q <= -14'sd7) begin
						rm_q <= {8'd0, rm_q[105:9], |rm_q[8:0]};
						re_q <= re_q + 14'sd8;
					end else begin
						rm_q <= {1'b0, rm_q[105:2], |rm_q[1:0]};
						re_q <= re_q + 14'sd1;
					end
				end else if (!rm_q[104] && (re_q > 14'sd1)) begin
					if ((rm_q[104:97] == 8'd0) && (re_q > 14'sd8)) begin
						rm_q <= {rm_q[97:0], 8'd0};
						re_q <= re_q - 14'sd8;
					end else begin
						rm_q <= {rm_q[104:0], 1'b0};
						re_q <= re_q - 14'sd1;
					end
				end
			end
			F_ROUND: y_q <= round_y;
			default: ;
		endcase
	end

endmodule

// ===== rtl/core/amg_direct_interpolation_row_core.sv =====
// direct-interpolation row core: per-row sums, strong-entry buffer, weight emission
// depends on amg_dir_pkg, amg_dir_fpu, amg_dir_ram and the assertion macro header
`include "amg_direct_interpolation_row_core_macros.svh"

// an off-diagonal entry takes one or two double adds in the shared unit;
// diagonal and coarse entries take none
// row end: up to three divides, two multiplies, then a ram read and a multiply per weight
// one beat in flight at a time; each weight is strobed for a single cycle
// reset clears sums, counts and control; buffer contents are left undefined
module amg_direct_interpolation_row_core #(
	parameter int MAX_STRONG  = 64,
	parameter int COLUMN_BITS = 24
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  amg_dir_pkg::in_item_t  item,
	output logic                   busy,
	output logic                   strobe,
	output amg_dir_pkg::out_item_t result
);
	import amg_dir_pkg::*;

	localparam int CW = $clog2(MAX_STRONG + 1);
	localparam int AW = (MAX_STRONG > 1) ? $clog2(MAX_STRONG) : 1;
	localparam int RW = COLUMN_BITS + 64;

	ctl_state_t st_q, st_d;

	in_item_t    item_q;
	logic [63:0] aneg_q, apos_q, sneg_q, spos_q, diag_q;
	logic [63:0] alpha_q, beta_q, r_q;
	logic [CW-1:0] cnt_q, idx_q;
	logic        ovf_q;
	logic        wait_q;
	logic        strobe_q;
	out_item_t   res_q;

	fpu_req_t fpu_req;
	fpu_rsp_t fpu_rsp;

	logic          accept;
	logic          need_op, fpu_fin, step;
	logic          emit, clear, rd;
	out_item_t     emit_res;
	logic          ram_we;
	logic [RW-1:0] ram_rdata;
	logic [63:0]   v, wv;
	logic          last_w;

	assign busy    = (st_q != C_IDLE);
	assign accept  = start && !busy;
	assign v       = item_q.entry_value;
	assign wv      = ram_rdata[63:0];
	assign last_w  = (idx_q + CW'(1)) == cnt_q;
	assign fpu_fin = wait_q && fpu_rsp.done;
	assign step    = !need_op || fpu_fin;
	assign ram_we  = accept && !item.row_is_coarse && !item.is_diagonal
	                 && item.strong_coarse && (cnt_q < CW'(MAX_STRONG));

	amg_dir_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	amg_dir_ram #(
		.WIDTH (RW),
		.DEPTH (MAX_STRONG)
	) u_buf (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata ({COLUMN_BITS'(item.neighbour_coarse_column), item.entry_value}),
		.re    (rd),
		.raddr (idx_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			C_IDLE: begin
				if (start) begin
					if (item.row_is_coarse || item.is_diagonal) begin
						st_d = item.last_entry ? C_END : C_IDLE;
					end else begin
						st_d = C_ACC_ALL;
					end
				end
			end
			C_ACC_ALL: begin
				if (step) begin
					if (item_q.strong_coarse)   st_d = C_ACC_STRONG;
					else if (item_q.last_entry) st_d = C_END;
					else                        st_d = C_IDLE;
				end
			end
			C_ACC_STRONG: if (step) st_d = item_q.last_entry ? C_END : C_IDLE;
			C_END: begin
				st_d = (item_q.row_is_coarse || (cnt_q == '0)) ? C_IDLE : C_ALPHA;
			end
			C_ALPHA:   if (step) st_d = C_BETA;
			C_BETA:    if (step) st_d = C_RECIP;
			C_RECIP:   if (step) st_d = dbl_is_pos(diag_q) ? C_SCALE_A : C_READ;
			C_SCALE_A: if (step) st_d = C_SCALE_B;
			C_SCALE_B: if (step) st_d = C_READ;
			C_READ:    st_d = C_WEIGHT;
			C_WEIGHT:  if (step) st_d = last_w ? C_IDLE : C_READ;
			default:   st_d = C_IDLE;
		endcase
	end

	// outputs and unit requests
	always_comb begin
		need_op  = 1'b0;
		fpu_req  = '{go: 1'b0, op: OP_ADD, a: DBL_ZERO, b: DBL_ZERO};
		emit     = 1'b0;
		emit_res = '0;
		clear    = 1'b0;
		rd       = 1'b0;
		unique case (st_q)
			C_ACC_ALL: begin
				need_op   = 1'b1;
				fpu_req.a = dbl_is_neg(v) ? aneg_q : apos_q;
				fpu_req.b = v;
			end
			C_ACC_STRONG: begin
				need_op   = 1'b1;
				fpu_req.a = dbl_is_neg(v) ? sneg_q : spos_q;
				fpu_req.b = v;
			end
			C_END: begin
				if (item_q.row_is_coarse) begin
					emit     = 1'b1;
					emit_res = '{weight_column: 24'(COLUMN_BITS'(item_q.row_coarse_column)),
					             weight_value: DBL_ONE, row_overflow: 1'b0,
					             last_weight: 1'b1};
					clear    = 1'b1;
				end else if (cnt_q == '0) begin
					clear = 1'b1;
				end
			end
			C_ALPHA: begin
				need_op    = dbl_is_neg(sneg_q);
				fpu_req.op = OP_DIV;
				fpu_req.a  = aneg_q;
				fpu_req.b  = sneg_q;
			end
			C_BETA: begin
				need_op = 1'b1;
				if (dbl_is_pos(spos_q)) begin
					fpu_req.op = OP_DIV;
					fpu_req.a  = apos_q;
					fpu_req.b  = spos_q;
				end else begin
					fpu_req.a = diag_q;
					fpu_req.b = apos_q;
				end
			end
			C_RECIP: begin
				need_op    = dbl_is_pos(diag_q);
				fpu_req.op = OP_DIV;
				fpu_req.a  = DBL_NEG_ONE;
				fpu_req.b  = diag_q;
			end
			C_SCALE_A: begin
				need_op    = 1'b1;
				fpu_req.op = OP_MUL;
				fpu_req.a  = alpha_q;
				fpu_req.b  = r_q;
			end
			C_SCALE_B: begin
				need_op    = 1'b1;
				fpu_req.op = OP_MUL;
				fpu_req.a  = beta_q;
				fpu_req.b  = r_q;
			end
			C_READ: rd = 1'b1;
			C_WEIGHT: begin
				need_op    = 1'b1;
				fpu_req.op = OP_MUL;
				fpu_req.a  = wv;
				fpu_req.b  = dbl_is_pos(wv) ? beta_q : alpha_q;
				if (fpu_fin) begin
					emit     = 1'b1;
					emit_res = '{weight_column: 24'(ram_rdata[RW-1:64]),
					             weight_value: fpu_rsp.y, row_overflow: ovf_q,
					             last_weight: last_w};
					clear    = last_w;
				end
			end
			default: ;
		endcase
		fpu_req.go = need_op && !wait_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= C_IDLE;
			wait_q   <= 1'b0;
			strobe_q <= 1'b0;
			cnt_q    <= '0;
			idx_q    <= '0;
			ovf_q    <= 1'b0;
			aneg_q   <= DBL_ZERO;
			apos_q   <= DBL_ZERO;
			sneg_q   <= DBL_ZERO;
			spos_q   <= DBL_ZERO;
			diag_q   <= DBL_ZERO;
		end else begin
			st_q     <= st_d;
			strobe_q <= emit;
			if (fpu_req.go) begin
				wait_q <= 1'b1;
			end else if (fpu_fin) begin
				wait_q <= 1'b0;
			end

			if (accept && !item.row_is_coarse) begin
				if (item.is_diagonal) begin
					diag_q <= item.entry_value;
				end else if (item.strong_coarse) begin
					if (cnt_q < CW'(MAX_STRONG)) begin
						cnt_q <= cnt_q + CW'(1);
					end else begin
						ovf_q <= 1'b1;
					end
				end
			end

			if (fpu_fin) begin
				unique case (st_q)
					C_ACC_ALL: begin
						if (dbl_is_neg(v)) aneg_q <= fpu_rsp.y;
						else               apos_q <= fpu_rsp.y;
					end
					C_ACC_STRONG: begin
						if (dbl_is_neg(v)) sneg_q <= fpu_rsp.y;
						else               spos_q <= fpu_rsp.y;
					end
					C_BETA: if (!dbl_is_pos(spos_q)) diag_q <= fpu_rsp.y;
					default: ;
				endcase
			end

			if (st_q == C_WEIGHT && fpu_fin && !last_w) begin
				idx_q <= idx_q + CW'(1);
			end

			// row done: back to the reset picture
			if (clear) begin
				cnt_q  <= '0;
				idx_q  <= '0;
				ovf_q  <= 1'b0;
				aneg_q <= DBL_ZERO;
				apos_q <= DBL_ZERO;
				sneg_q <= DBL_ZERO;
				spos_q <= DBL_ZERO;
				diag_q <= DBL_ZERO;
			end
		end
	end

	// row-end coefficients and latched beat
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		if (emit) begin
			res_q <= emit_res;
		end
		unique case (st_q)
			C_ALPHA:   alpha_q <= fpu_fin ? fpu_rsp.y : DBL_ZERO;
			C_BETA: begin
				if (fpu_fin) beta_q <= dbl_is_pos(spos_q) ? fpu_rsp.y : DBL_ZERO;
			end
			C_RECIP:   if (fpu_fin) r_q <= fpu_rsp.y;
			C_SCALE_A: if (fpu_fin) alpha_q <= fpu_rsp.y;
			C_SCALE_B: if (fpu_fin) beta_q <= fpu_rsp.y;
			default: ;
		endcase
	end

	assign strobe = strobe_q;
	assign result = res_q;

	`AMG_DIR_ASSERT(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CW'(MAX_STRONG), "strong count past buffer depth")
	`AMG_DIR_ASSERT(a_unit_owned, clk, arst_n, wait_q, busy, "double unit in flight while idle")
	`AMG_DIR_ASSERT(a_no_stray_done, clk, arst_n, fpu_rsp.done, wait_q, "double unit answered unasked")
	`AMG_DIR_ASSERT(a_row_cleared, clk, arst_n, strobe && result.last_weight, cnt_q == '0, "row state left after last weight")
	`AMG_DIR_ASSERT_NEXT(a_strobe_gap, clk, arst_n, strobe, !strobe, "weights strobed back to back")

endmodule
